>>> hw/rtl/dre_pkg.sv
// Shared constants for the DAG reachability engine.
// Used by the adjacency memory and the top level; no dependencies.
`default_nettype none

package dre_pkg;

  localparam int ROW_W         = 64;
  localparam int NODE_W        = 6;
  localparam int CNT_W         = 7;
  localparam int MASK_W        = 63;
  localparam int DEF_MAX_NODES = 64;

  localparam logic CMD_REFRESH = 1'b0;
  localparam logic CMD_QUERY   = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/dag_reachability_engine_unit.sv
// Top level of the DAG reachability engine: command sequencer, closure
// sweep and column refresh. Depends on dre_pkg and dre_adj_mem.
//
// Usage: a command word is taken when start is high and busy is low.
// A refresh word (in_command low) rewrites the incoming column of in_node
// from in_parent_mask and gives no result. A query word returns one result
// word, out_source_node and out_reach_mask, shown for exactly one cycle with
// out_valid high. Words naming a node at or above the active node count are
// dropped at once and leave busy low.
// With n the active node count, a refresh keeps busy high while it does
// one read-modify-write of an adjacency row per cycle through the
// single memory port pair. A query runs s sweeps over the rows, with s
// between 1 and n depending on how the edges are ordered; out_valid rises
// in the cycle after the last sweep ends. One word is in work at a time.
// The receiver cannot stall; results are never held back.
// cfg_we writes the node count register at any edge, meant for idle times.
// Reset clears the graph (no edges), sets the node count to 64 and makes
// the block idle; the row valid bits clear at once, with no clearing pass.

`default_nettype none

module dag_reachability_engine_unit
  import dre_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_command,
  input  wire logic [NODE_W-1:0] in_node,
  input  wire logic [MASK_W-1:0] in_parent_mask,
  output logic                   out_valid,
  output logic      [NODE_W-1:0] out_source_node,
  output logic      [ROW_W-1:0]  out_reach_mask,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_wdata
);

  localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_NODES);
  localparam logic [CNT_W-1:0] MIN_N = CNT_W'(2);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_REFRESH = 2'd1;
  localparam logic [1:0] ST_QUERY   = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  node_count_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              rvld_r, rvld_nxt;
  logic [NODE_W-1:0] rrow_r, rrow_nxt;
  logic [NODE_W-1:0] tgt_r, tgt_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic [ROW_W-1:0]  reach_r, reach_nxt;
  logic [ROW_W-1:0]  done_r, done_nxt;
  logic [ROW_W-1:0]  keep_r, keep_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_src_r, out_src_nxt;
  logic [ROW_W-1:0]  out_reach_r, out_reach_nxt;

  logic [CNT_W-1:0]  n_c;
  logic [ROW_W-1:0]  keep_c;
  logic              accept;
  logic              issue;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ROW_W-1:0]  rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ROW_W-1:0]  wr_data;
  logic [ROW_W-1:0]  tgt_bit;
  logic              new_bit;

  always_comb begin
    if (node_count_r < MIN_N) begin
      n_c = MIN_N;
    end else if (node_count_r > MAX_N) begin
      n_c = MAX_N;
    end else begin
      n_c = node_count_r;
    end
  end

  always_comb begin
    for (int k = 0; k < ROW_W; k++) begin
      keep_c[k] = (CNT_W'(k) < n_c);
    end
  end

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign issue   = busy && (cnt_r < n_c);
  assign rd_en   = issue;
  assign rd_addr = cnt_r[ADDR_W-1:0];
  assign tgt_bit = ROW_W'(1) << tgt_r;
  assign new_bit = (rrow_r == tgt_r) ? 1'b0 : mask_r[0];
  assign wr_en   = (state_r == ST_REFRESH) && rvld_r;
  assign wr_addr = rrow_r[ADDR_W-1:0];
  assign wr_data = (rd_data & ~tgt_bit) | (new_bit ? tgt_bit : '0);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rvld_nxt      = issue;
    rrow_nxt      = cnt_r[NODE_W-1:0];
    tgt_nxt       = tgt_r;
    mask_nxt      = mask_r;
    reach_nxt     = reach_r;
    done_nxt      = done_r;
    keep_nxt      = keep_r;
    out_valid_nxt = 1'b0;
    out_src_nxt   = out_src_r;
    out_reach_nxt = out_reach_r;
    if (issue) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    case (state_r)
      ST_IDLE: begin
        if (accept && ({1'b0, in_node} < n_c)) begin
          cnt_nxt   = '0;
          tgt_nxt   = in_node;
          mask_nxt  = in_parent_mask;
          keep_nxt  = keep_c;
          reach_nxt = ROW_W'(1) << in_node;
          done_nxt  = '0;
          state_nxt = (in_command == CMD_QUERY) ? ST_QUERY : ST_REFRESH;
        end
      end
      ST_REFRESH: begin
        if (rvld_r && (rrow_r != tgt_r)) begin
          mask_nxt = mask_r >> 1;
        end
        if (!issue && !rvld_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (rvld_r && reach_r[rrow_r] && !done_r[rrow_r]) begin
          reach_nxt        = reach_r | (rd_data & keep_r);
          done_nxt[rrow_r] = 1'b1;
        end
        if (!issue && !rvld_r) begin
          if ((reach_r & ~done_r) == '0) begin
            out_valid_nxt = 1'b1;
            out_src_nxt   = tgt_r;
            out_reach_nxt = reach_r;
            state_nxt     = ST_IDLE;
          end else begin
            cnt_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= CNT_W'(64);
      cnt_r        <= '0;
      rvld_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rrow_r      <= rrow_nxt;
    tgt_r       <= tgt_nxt;
    mask_r      <= mask_nxt;
    reach_r     <= reach_nxt;
    done_r      <= done_nxt;
    keep_r      <= keep_nxt;
    out_src_r   <= out_src_nxt;
    out_reach_r <= out_reach_nxt;
  end

  dre_adj_mem #(
    .DEPTH  (MAX_NODES),
    .ADDR_W (ADDR_W)
  ) u_adj_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign out_valid       = out_valid_r;
  assign out_source_node = out_src_r;
  assign out_reach_mask  = out_reach_r;

endmodule

`default_nettype wire

>>> hw/rtl/dre_adj_mem.sv
// Adjacency row memory with one write port, one registered read port and
// per-row valid bits so that unwritten rows read as zero. Uses dre_pkg.
`default_nettype none

module dre_adj_mem
  import dre_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_NODES,
  parameter int ADDR_W = $clog2(DEF_MAX_NODES)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [ROW_W-1:0]  rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [ROW_W-1:0]  wr_data
);

  logic [ROW_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] row_vld_r;
  logic [ROW_W-1:0] rdata_r;
  logic             rsel_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rsel_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rsel_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rsel_r ? rdata_r : '0;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for dag_reachability_engine_unit: random and directed
// refresh and query words, predicted results compared at the output strobe.
// Depends on dre_pkg and the engine RTL.
`default_nettype none

module testbench;
  import dre_pkg::*;

  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic              cmd;
    logic [NODE_W-1:0] node;
    logic [MASK_W-1:0] pmask;
  } cmd_word_t;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [ROW_W-1:0]  reach;
  } reach_rec_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_command = 1'b0;
  logic [NODE_W-1:0] in_node = '0;
  logic [MASK_W-1:0] in_parent_mask = '0;
  logic              out_valid;
  logic [NODE_W-1:0] out_source_node;
  logic [ROW_W-1:0]  out_reach_mask;
  logic              cfg_we = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata = '0;

  cmd_word_t  word_q[$];
  reach_rec_t reach_exp_q[$];
  logic [ROW_W-1:0] graph_rows [DEF_MAX_NODES];
  logic [CNT_W-1:0] node_limit;
  int err_cnt = 0;
  int cyc_cnt = 0;
  int burst_left;
  int gap_left;

  dag_reachability_engine_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_node        (in_node),
    .in_parent_mask (in_parent_mask),
    .out_valid      (out_valid),
    .out_source_node(out_source_node),
    .out_reach_mask (out_reach_mask),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic int nodes_in_use(logic [CNT_W-1:0] cnt);
    int n;
    n = int'(cnt);
    if (n < 2) n = 2;
    if (n > DEF_MAX_NODES) n = DEF_MAX_NODES;
    return n;
  endfunction

  function automatic int parent_bit(int p, int t);
    return (p < t) ? p : p - 1;
  endfunction

  function automatic void refresh_column(int tgt, logic [MASK_W-1:0] pmask, int n);
    int row;
    for (int r = 0; r < n; r++) graph_rows[r][tgt] = 1'b0;
    for (int j = 0; j + 1 < n; j++) begin
      if (pmask[j]) begin
        row = (j >= tgt) ? j + 1 : j;
        graph_rows[row][tgt] = 1'b1;
      end
    end
  endfunction

  function automatic logic [ROW_W-1:0] reach_from(int src, int n);
    logic [ROW_W-1:0] keep;
    logic [ROW_W-1:0] reach;
    logic [ROW_W-1:0] nxt;
    bit grew;
    keep = (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
    reach = ROW_W'(1) << src;
    grew = 1'b1;
    while (grew) begin
      nxt = reach;
      for (int k = 0; k < n; k++)
        if (reach[k]) nxt |= graph_rows[k] & keep;
      grew = (nxt != reach);
      reach = nxt;
    end
    return reach;
  endfunction

  function automatic void predict_word(cmd_word_t w);
    int n;
    reach_rec_t rec;
    n = nodes_in_use(node_limit);
    if (int'(w.node) < n) begin
      if (w.cmd == CMD_REFRESH) begin
        refresh_column(int'(w.node), w.pmask, n);
      end else begin
        rec.src = w.node;
        rec.reach = reach_from(int'(w.node), n);
        reach_exp_q = {reach_exp_q, rec};
      end
    end
  endfunction

  always @(posedge clk) begin
    cmd_word_t w;
    bit fire;
    if (!rst_n) begin
      start <= 1'b0;
      node_limit = CNT_W'(DEF_MAX_NODES);
      for (int r = 0; r < DEF_MAX_NODES; r++) graph_rows[r] = '0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (cfg_we) node_limit = cfg_wdata;
      fire = start && !busy;
      if (fire) predict_word('{in_command, in_node, in_parent_mask});
      if (!start || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (word_q.size() != 0) begin
          w = word_q.pop_front();
          in_command <= w.cmd;
          in_node <= w.node;
          in_parent_mask <= w.pmask;
          start <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(7) == 0) begin
              burst_left = $urandom_range(60, 30);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(12, 1);
              gap_left = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(6);
            end
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    reach_rec_t exp_rec;
    if (rst_n && out_valid) begin
      if (reach_exp_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result word src=%0d reach=%h", $time, out_source_node,
                 out_reach_mask);
      end else begin
        exp_rec = reach_exp_q.pop_front();
        if (out_source_node !== exp_rec.src) begin
          err_cnt++;
          $display("%0t: source_node expected %0d actual %0d", $time, exp_rec.src,
                   out_source_node);
        end
        if (out_reach_mask !== exp_rec.reach) begin
          err_cnt++;
          $display("%0t: reach_mask expected %h actual %h", $time, exp_rec.reach,
                   out_reach_mask);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_word(logic cmd, int node, logic [MASK_W-1:0] pmask);
    cmd_word_t w;
    w.cmd = cmd;
    w.node = NODE_W'(node);
    w.pmask = pmask;
    word_q = {word_q, w};
  endtask

  task automatic push_random(int n);
    int sel;
    int t;
    int p;
    int k;
    logic [MASK_W-1:0] m;
    sel = $urandom_range(99);
    t = $urandom_range(n - 1);
    m = '0;
    if (sel < 30) begin
      k = $urandom_range(3);
      repeat (k) begin
        p = $urandom_range(n - 1);
        if (p != t) m[parent_bit(p, t)] = 1'b1;
      end
      push_word(CMD_REFRESH, t, m);
    end else if (sel < 40) begin
      m = MASK_W'({$urandom, $urandom});
      push_word(CMD_REFRESH, t, m);
    end else if (sel < 45) begin
      t = $urandom_range(n - 1, 1);
      m[parent_bit(t - 1, t)] = 1'b1;
      push_word(CMD_REFRESH, t, m);
    end else if (sel < 50) begin
      t = $urandom_range(n - 2);
      m[parent_bit(t + 1, t)] = 1'b1;
      push_word(CMD_REFRESH, t, m);
    end else if (sel < 95) begin
      push_word(CMD_QUERY, t, MASK_W'({$urandom, $urandom}));
    end else begin
      m = MASK_W'({$urandom, $urandom});
      push_word(1'($urandom_range(1)), int'($urandom_range(63)), m);
    end
  endtask

  task automatic drain;
    do @(posedge clk);
    while (word_q.size() != 0 || start || busy || reach_exp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase_cnt [12];
    int phase_len [12];
    int n;
    phase_cnt = '{2, 0, 5, 13, 64, 8, 127, 33, 1, 3, 100, 20};
    phase_len = '{40, 30, 70, 90, 45, 80, 35, 70, 20, 50, 30, 90};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_word(CMD_QUERY, 0, '0);
    push_word(CMD_QUERY, 63, '1);
    push_word(CMD_REFRESH, 0, '1);
    push_word(CMD_QUERY, 63, '0);
    push_word(CMD_REFRESH, 63, '1);
    push_word(CMD_QUERY, 0, '0);
    push_word(CMD_QUERY, 17, '0);
    push_word(CMD_REFRESH, 32, MASK_W'({32{2'b01}}));
    push_word(CMD_QUERY, 32, '0);
    push_word(CMD_QUERY, 1, '0);
    push_word(CMD_REFRESH, 1, MASK_W'(1));
    push_word(CMD_REFRESH, 2, MASK_W'(2));
    push_word(CMD_REFRESH, 5, MASK_W'(1) << (MASK_W - 1));
    push_word(CMD_QUERY, 2, '0);
    push_word(CMD_QUERY, 62, '0);
    push_word(CMD_REFRESH, 0, '0);
    push_word(CMD_QUERY, 5, '0);
    push_word(CMD_REFRESH, 63, '0);
    push_word(CMD_QUERY, 2, '0);
    push_word(CMD_QUERY, 63, '0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      write_count(phase_cnt[ph]);
      n = nodes_in_use(CNT_W'(phase_cnt[ph]));
      push_word(CMD_REFRESH, 63, '1);
      push_word(CMD_QUERY, 63, '0);
      push_word(CMD_QUERY, n - 1, '0);
      push_word(CMD_REFRESH, n - 1, '1);
      for (int i = 0; i < phase_len[ph]; i++) push_random(n);
      drain();
    end

    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/dre_pkg.sv
hw/rtl/dre_adj_mem.sv
hw/rtl/dag_reachability_engine_unit.sv
tb/sv/testbench.sv
